>>> hdl/csl_pkg.sv
// Package for the C-subset lexer: beat types, token kind codes, queue sizing
// and the character class and keyword helper functions.
// No dependencies; every other file of the block imports it.
package csl_pkg;

   localparam int LINE_WIDTH_DEF    = 16;
   localparam int OFFSET_WIDTH_DEF  = 24;
   localparam int KEYWORD_CHARS_DEF = 6;
   localparam int MAX_RESULTS       = 3;
   localparam int QUEUE_DEPTH       = 8;
   localparam int LEN_WIDTH         = 16;

   localparam logic [5:0] K_IDENT   = 6'd1;
   localparam logic [5:0] K_INTEGER = 6'd2;
   localparam logic [5:0] K_REAL    = 6'd3;
   localparam logic [5:0] K_INT     = 6'd4;
   localparam logic [5:0] K_DOUBLE  = 6'd5;
   localparam logic [5:0] K_VOID    = 6'd6;
   localparam logic [5:0] K_AUTO    = 6'd7;
   localparam logic [5:0] K_FOR     = 6'd8;
   localparam logic [5:0] K_IF      = 6'd9;
   localparam logic [5:0] K_ELSE    = 6'd10;
   localparam logic [5:0] K_RETURN  = 6'd11;
   localparam logic [5:0] K_QREG    = 6'd12;
   localparam logic [5:0] K_BIT     = 6'd13;
   localparam logic [5:0] K_ORACLE  = 6'd14;
   localparam logic [5:0] K_LBRACK  = 6'd15;
   localparam logic [5:0] K_RBRACK  = 6'd16;
   localparam logic [5:0] K_LPAREN  = 6'd17;
   localparam logic [5:0] K_RPAREN  = 6'd18;
   localparam logic [5:0] K_LBRACE  = 6'd19;
   localparam logic [5:0] K_RBRACE  = 6'd20;
   localparam logic [5:0] K_COMMA   = 6'd21;
   localparam logic [5:0] K_SEMI    = 6'd22;
   localparam logic [5:0] K_COLON   = 6'd23;
   localparam logic [5:0] K_DOT     = 6'd24;
   localparam logic [5:0] K_ANDAND  = 6'd25;
   localparam logic [5:0] K_ARROW   = 6'd26;
   localparam logic [5:0] K_LATTR   = 6'd27;
   localparam logic [5:0] K_RATTR   = 6'd28;
   localparam logic [5:0] K_ASSIGN  = 6'd29;
   localparam logic [5:0] K_EQ      = 6'd30;
   localparam logic [5:0] K_NE      = 6'd31;
   localparam logic [5:0] K_LT      = 6'd32;
   localparam logic [5:0] K_GT      = 6'd33;
   localparam logic [5:0] K_LE      = 6'd34;
   localparam logic [5:0] K_GE      = 6'd35;
   localparam logic [5:0] K_PLUS    = 6'd36;
   localparam logic [5:0] K_MINUS   = 6'd37;
   localparam logic [5:0] K_STAR    = 6'd38;
   localparam logic [5:0] K_SLASH   = 6'd39;
   localparam logic [5:0] K_INC     = 6'd40;
   localparam logic [5:0] K_DEC     = 6'd41;
   localparam logic [5:0] K_SCOPE   = 6'd42;
   localparam logic [5:0] K_EOF     = 6'd43;
   localparam logic [5:0] K_UNKNOWN = 6'd44;
   localparam logic [5:0] K_NONE    = 6'd0;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [23:0] start_offset;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              count;
      rsp_type [MAX_RESULTS-1:0] item;
   } csl_wr_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_pairable(logic [7:0] c);
      return (c == "[") || (c == "]") || (c == "+") || (c == "-") || (c == ":") ||
             (c == "=") || (c == "!") || (c == "<") || (c == ">") || (c == "&") ||
             (c == "/");
   endfunction

   function automatic logic [5:0] single_kind(logic [7:0] c);
      logic [5:0] k;
      case (c)
         "[":     k = K_LBRACK;
         "]":     k = K_RBRACK;
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         ",":     k = K_COMMA;
         ";":     k = K_SEMI;
         ":":     k = K_COLON;
         ".":     k = K_DOT;
         "=":     k = K_ASSIGN;
         "<":     k = K_LT;
         ">":     k = K_GT;
         "+":     k = K_PLUS;
         "-":     k = K_MINUS;
         "*":     k = K_STAR;
         "/":     k = K_SLASH;
         default: k = K_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] pair_kind(logic [7:0] a, logic [7:0] b);
      logic [5:0] k;
      k = K_NONE;
      if (a == "[" && b == "[") k = K_LATTR;
      if (a == "]" && b == "]") k = K_RATTR;
      if (a == "+" && b == "+") k = K_INC;
      if (a == "-" && b == "-") k = K_DEC;
      if (a == "-" && b == ">") k = K_ARROW;
      if (a == ":" && b == ":") k = K_SCOPE;
      if (a == "=" && b == "=") k = K_EQ;
      if (a == "!" && b == "=") k = K_NE;
      if (a == "<" && b == "=") k = K_LE;
      if (a == ">" && b == "=") k = K_GE;
      if (a == "&" && b == "&") k = K_ANDAND;
      return k;
   endfunction

   // Reorders a string literal so that its first character sits in the low byte.
   function automatic logic [63:0] kw_pack(logic [63:0] s, int n);
      logic [63:0] r;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         if (j < n) r[8*j +: 8] = s[8*(n-1-j) +: 8];
      end
      return r;
   endfunction

   function automatic logic [5:0] ident_kind(logic [63:0] kw, logic [15:0] len);
      logic [5:0] k;
      k = K_IDENT;
      if      (len == 16'd3 && kw == kw_pack(64'("int"), 3))    k = K_INT;
      else if (len == 16'd6 && kw == kw_pack(64'("double"), 6)) k = K_DOUBLE;
      else if (len == 16'd5 && kw == kw_pack(64'("float"), 5))  k = K_DOUBLE;
      else if (len == 16'd4 && kw == kw_pack(64'("void"), 4))   k = K_VOID;
      else if (len == 16'd4 && kw == kw_pack(64'("auto"), 4))   k = K_AUTO;
      else if (len == 16'd3 && kw == kw_pack(64'("for"), 3))    k = K_FOR;
      else if (len == 16'd2 && kw == kw_pack(64'("if"), 2))     k = K_IF;
      else if (len == 16'd4 && kw == kw_pack(64'("else"), 4))   k = K_ELSE;
      else if (len == 16'd6 && kw == kw_pack(64'("return"), 6)) k = K_RETURN;
      else if (len == 16'd4 && kw == kw_pack(64'("QReg"), 4))   k = K_QREG;
      else if (len == 16'd3 && kw == kw_pack(64'("Bit"), 3))    k = K_BIT;
      else if (len == 16'd3 && kw == kw_pack(64'("bit"), 3))    k = K_BIT;
      else if (len == 16'd6 && kw == kw_pack(64'("Oracle"), 6)) k = K_ORACLE;
      return k;
   endfunction

endpackage

>>> hdl/csl_queue.sv
// Token queue between the lexer front and the result port.
// Takes up to three beats per cycle from the front; depends on csl_pkg.
module csl_queue
   import csl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csl_wr_type wr,
   output logic       full,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   rsp_type        mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]  head_ff, head_in;
   logic [AW-1:0]  tail_ff, tail_in;
   logic [AW:0]    count_ff, count_in;
   logic           pop_ok;

   assign pop_ok    = rsp_pop && (count_ff != '0);
   assign rsp_empty = (count_ff == '0);
   assign full      = (count_ff > (AW+1)'(QUEUE_DEPTH - MAX_RESULTS));
   assign rsp_data  = mem_ff[head_ff];

   always_comb begin
      head_in  = pop_ok ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + AW'(wr.count);
      count_in = count_ff + (AW+1)'(wr.count) - (AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (i < int'(wr.count)) mem_ff[tail_ff + AW'(i)] <= wr.item[i];
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/csl_front.sv
// Lexer front: holds mode, token and position state and turns one source beat
// into up to three token beats per cycle. Depends on csl_pkg.
module csl_front
   import csl_pkg::*;
#(
   parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
   parameter int OFFSET_WIDTH  = OFFSET_WIDTH_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   output csl_wr_type wr
);

   localparam int LW = LINE_WIDTH;
   localparam int OW = OFFSET_WIDTH;
   localparam int KB = 8 * KEYWORD_CHARS;
   localparam int SW = ((LW > LEN_WIDTH) ? LW : LEN_WIDTH) + 1;
   localparam logic [LW-1:0] LINE_MAX = '1;
   localparam logic [OW-1:0] OFF_MAX  = '1;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_EXP, M_EXPD,
      M_HELD, M_LINE, M_BLOCK, M_BSTAR
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic [7:0]           held_ff, held_in;
   logic [LW-1:0]        tsl_ff, tsl_in, tsc_ff, tsc_in;
   logic [OW-1:0]        tso_ff, tso_in;
   logic [LEN_WIDTH-1:0] tlen_ff, tlen_in;
   logic [KB-1:0]        kwb_ff, kwb_in;
   logic [LW-1:0]        line_ff, line_in, col_ff, col_in;
   logic [OW-1:0]        off_ff, off_in;
   csl_wr_type           wr_v;

   function automatic rsp_type mk(logic [5:0] k, logic [LW-1:0] ln, logic [LW-1:0] cl,
                                  logic [OW-1:0] of, logic [LEN_WIDTH-1:0] len);
      rsp_type r;
      r.token_kind   = k;
      r.start_line   = 16'(ln);
      r.start_column = 16'(cl);
      r.start_offset = 24'(of);
      r.token_length = len;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] len_inc(logic [LEN_WIDTH-1:0] a);
      return (a == LEN_MAX) ? a : a + 1'b1;
   endfunction

   always_comb begin
      logic [7:0]     c;
      logic           done;
      logic           freeze;
      logic           set_col;
      logic [1:0]     n;
      logic [5:0]     fk;
      logic [LEN_WIDTH-1:0] flen;
      logic           fl;
      logic [SW-1:0]  dsum;
      logic [LW-1:0]  dcol;
      logic           alpha_c, digit_c;

      c       = req_data.data_byte;
      alpha_c = is_alpha(c);
      digit_c = is_digit(c);
      done    = 1'b0;
      freeze  = 1'b0;
      set_col = 1'b0;
      n       = 2'd0;
      fk      = K_NONE;
      flen    = '0;
      fl      = 1'b0;
      wr_v    = '0;
      mode_in = mode_ff;
      held_in = held_ff;
      tsl_in  = tsl_ff;
      tsc_in  = tsc_ff;
      tso_in  = tso_ff;
      tlen_in = tlen_ff;
      kwb_in  = kwb_ff;
      line_in = line_ff;
      col_in  = col_ff;
      off_in  = off_ff;
      dsum    = SW'(tsc_ff) + SW'(tlen_ff);
      dcol    = (dsum > SW'(LINE_MAX)) ? LINE_MAX : LW'(dsum);

      if (req_data.command == CMD_END) begin
         case (mode_ff)
            M_IDENT: begin
               fl = 1'b1; fk = ident_kind(64'(kwb_ff), tlen_ff); flen = tlen_ff;
            end
            M_INT: begin
               fl = 1'b1; fk = K_INTEGER; flen = tlen_ff;
            end
            M_DOT: begin
               fl = 1'b1; fk = K_REAL; flen = len_inc(tlen_ff);
            end
            M_FRAC, M_EXP, M_EXPD: begin
               fl = 1'b1; fk = K_REAL; flen = tlen_ff;
            end
            M_HELD: begin
               fl = 1'b1; fk = single_kind(held_ff); flen = LEN_WIDTH'(1);
            end
            default: fl = 1'b0;
         endcase
         if (fl) begin
            wr_v.item[n] = mk(fk, tsl_ff, tsc_ff, tso_ff, flen);
            n = n + 1'b1;
         end
         wr_v.item[n] = mk(K_EOF, line_ff, col_ff, off_ff, '0);
         n = n + 1'b1;
         mode_in = M_IDLE;
         held_in = '0;
         tsl_in  = LW'(1);
         tsc_in  = LW'(1);
         tso_in  = '0;
         tlen_in = '0;
         kwb_in  = '0;
         line_in = LW'(1);
         col_in  = LW'(1);
         off_in  = '0;
      end else begin
         // A held dot after integer digits resolves first.
         if (mode_in == M_DOT) begin
            if (c == ".") begin
               wr_v.item[n] = mk(K_INTEGER, tsl_ff, tsc_ff, tso_ff, tlen_ff);
               n = n + 1'b1;
               wr_v.item[n] = mk(K_DOT, tsl_ff, dcol,
                                 (off_ff != '0) ? off_ff - 1'b1 : '0, LEN_WIDTH'(1));
               n = n + 1'b1;
               mode_in = M_IDLE;
            end else begin
               for (int j = 0; j < KEYWORD_CHARS; j++) begin
                  if (tlen_in == LEN_WIDTH'(j)) kwb_in[8*j +: 8] = ".";
               end
               tlen_in = len_inc(tlen_in);
               mode_in = M_FRAC;
            end
         end

         case (mode_in)
            M_IDENT: begin
               if (alpha_c || digit_c || c == "_") done = 1'b1;
               else begin
                  fl = 1'b1; fk = ident_kind(64'(kwb_in), tlen_in); flen = tlen_in;
               end
            end
            M_INT: begin
               if (digit_c) done = 1'b1;
               else if (c == ".") begin
                  mode_in = M_DOT;
                  done = 1'b1;
               end else if (c == "e" || c == "E") begin
                  mode_in = M_EXP;
                  done = 1'b1;
               end else begin
                  fl = 1'b1; fk = K_INTEGER; flen = tlen_in;
               end
            end
            M_FRAC: begin
               if (digit_c) done = 1'b1;
               else if (c == "e" || c == "E") begin
                  mode_in = M_EXP;
                  done = 1'b1;
               end else begin
                  fl = 1'b1; fk = K_REAL; flen = tlen_in;
               end
            end
            M_EXP: begin
               if (c == "+" || c == "-" || digit_c) begin
                  mode_in = M_EXPD;
                  done = 1'b1;
               end else begin
                  fl = 1'b1; fk = K_REAL; flen = tlen_in;
               end
            end
            M_EXPD: begin
               if (digit_c) done = 1'b1;
               else begin
                  fl = 1'b1; fk = K_REAL; flen = tlen_in;
               end
            end
            M_HELD: begin
               held_in = '0;
               if (pair_kind(held_ff, c) != K_NONE) begin
                  wr_v.item[n] = mk(pair_kind(held_ff, c), tsl_ff, tsc_ff, tso_ff,
                                    LEN_WIDTH'(2));
                  n = n + 1'b1;
                  mode_in = M_IDLE;
                  done = 1'b1;
               end else if (held_ff == "/" && c == "/") begin
                  mode_in = M_LINE;
                  set_col = 1'b1;
                  freeze  = 1'b1;
                  done    = 1'b1;
               end else if (held_ff == "/" && c == "*") begin
                  mode_in = M_BLOCK;
                  done = 1'b1;
               end else begin
                  fl = 1'b1; fk = single_kind(held_ff); flen = LEN_WIDTH'(1);
               end
            end
            M_LINE: begin
               if (c == 8'h0A) mode_in = M_IDLE;
               else begin
                  freeze = 1'b1;
                  done = 1'b1;
               end
            end
            M_BLOCK: begin
               if (c == "*") mode_in = M_BSTAR;
               done = 1'b1;
            end
            M_BSTAR: begin
               if (c == "/") mode_in = M_IDLE;
               else if (c != "*") mode_in = M_BLOCK;
               done = 1'b1;
            end
            M_IDLE: done = 1'b0;
            default: mode_in = M_IDLE;
         endcase

         // Characters that extend a token are appended here.
         if (done && (mode_in == M_IDENT || mode_in == M_INT || mode_in == M_FRAC ||
                      mode_in == M_EXP || mode_in == M_EXPD)) begin
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
               if (tlen_in == LEN_WIDTH'(j)) kwb_in[8*j +: 8] = c;
            end
            tlen_in = len_inc(tlen_in);
         end

         if (fl) begin
            wr_v.item[n] = mk(fk, tsl_ff, tsc_ff, tso_ff, flen);
            n = n + 1'b1;
            mode_in = M_IDLE;
         end

         if (!done) begin
            if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
               mode_in = M_IDLE;
            end else if (c == "#" && col_ff == LW'(1)) begin
               mode_in = M_LINE;
               freeze  = 1'b1;
            end else if (alpha_c || c == "_" || digit_c || is_pairable(c)) begin
               mode_in = alpha_c || c == "_" ? M_IDENT : (digit_c ? M_INT : M_HELD);
               tsl_in  = line_ff;
               tsc_in  = col_ff;
               tso_in  = off_ff;
               tlen_in = LEN_WIDTH'(1);
               kwb_in  = KB'(c);
               if (is_pairable(c) && !alpha_c && !digit_c) held_in = c;
            end else begin
               wr_v.item[n] = mk(single_kind(c), line_ff, col_ff, off_ff, LEN_WIDTH'(1));
               n = n + 1'b1;
            end
         end

         off_in = (off_ff == OFF_MAX) ? off_ff : off_ff + 1'b1;
         if (c == 8'h0A) begin
            line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
            col_in  = LW'(1);
         end else if (set_col) begin
            col_in = tsc_ff;
         end else if (!freeze) begin
            col_in = (col_ff == LINE_MAX) ? col_ff : col_ff + 1'b1;
         end
      end

      if (n != 2'd0) wr_v.item[n - 1'b1].last_of_run = 1'b1;
      wr_v.count = accept ? n : 2'd0;
   end

   assign wr = wr_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_ff <= '0;
         tsl_ff  <= LW'(1);
         tsc_ff  <= LW'(1);
         tso_ff  <= '0;
         tlen_ff <= '0;
         kwb_ff  <= '0;
         line_ff <= LW'(1);
         col_ff  <= LW'(1);
         off_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         tsl_ff  <= tsl_in;
         tsc_ff  <= tsc_in;
         tso_ff  <= tso_in;
         tlen_ff <= tlen_in;
         kwb_ff  <= kwb_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         off_ff  <= off_in;
      end
   end

endmodule

>>> hdl/c_subset_lexer_top.sv
// Top level of the C-subset lexer: lexer front feeding the token queue.
// Depends on csl_pkg, csl_front and csl_queue.
//
// While req_full is low the lexer takes one source beat per clock cycle and
// writes the zero to three token beats it causes into an eight-entry queue in
// the same cycle. It reports full when fewer than three entries are free, so the
// sustained rate is one source byte per cycle as long as tokens are popped about
// as fast as they are made. The end-of-source beat flushes any pending token,
// adds an end token and returns all counters to their reset values.
module c_subset_lexer_top
   import csl_pkg::*;
#(
   parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
   parameter int OFFSET_WIDTH  = OFFSET_WIDTH_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   csl_wr_type wr;
   logic       accept;

   assign accept = req_push && !req_full;

   csl_front #(
      .LINE_WIDTH   (LINE_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .KEYWORD_CHARS(KEYWORD_CHARS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req_data(req_data),
      .wr      (wr)
   );

   csl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .full     (req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_END) |-> (wr.count != 2'd0))
      else $error("end-of-source beat produced no token");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> (wr.count == 2'd0))
      else $error("token written while queue full");

   a_end_visible: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_END) |=> !rsp_empty)
      else $error("end token not queued");

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the C-subset lexer: a source-byte driver, a token monitor
// and a behavioral tokenizer that predicts every token beat. Depends on csl_pkg and
// c_subset_lexer_top.
module tb;
   import csl_pkg::*;

   localparam logic [3:0] LM_IDLE = 4'd0, LM_IDENT = 4'd1, LM_INT = 4'd2, LM_DOT = 4'd3,
      LM_FRAC = 4'd4, LM_EXP = 4'd5, LM_EXPD = 4'd6, LM_HELD = 4'd7, LM_LINE = 4'd8,
      LM_BLOCK = 4'd9, LM_BSTAR = 4'd10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic rsp_pop = 1'b0;
   logic req_full, rsp_empty;
   rsp_type rsp_data;

   req_type pending_bytes[$];
   rsp_type token_queue[$];
   int mismatches = 0;
   int send_idle_pct = 19;
   int recv_idle_pct = 86;
   int hold_cycles = 0;
   bit source_done = 1'b0;

   // Lexer state mirror.
   logic [3:0]  lx_mode;
   logic [7:0]  lx_held;
   logic [15:0] tk_line, tk_col, tk_len;
   logic [23:0] tk_off;
   logic [47:0] kw_buf;
   logic [15:0] cur_line, cur_col;
   logic [23:0] cur_off;
   logic [15:0] at_line, at_col;
   logic [23:0] at_off;
   bit          col_frozen;
   rsp_type     step_tokens[$];

   c_subset_lexer_top DUT (.*);

   always #1 clock = ~clock;

   function automatic logic [15:0] inc16(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic logic [47:0] word6(string s);
      logic [47:0] w;
      w = '0;
      for (int j = 0; j < s.len(); j++) w[8*j +: 8] = s[j];
      return w;
   endfunction

   function automatic logic [5:0] keyword_of(logic [47:0] kw, logic [15:0] len);
      if (len == 3 && kw == word6("int")) return K_INT;
      if (len == 6 && kw == word6("double")) return K_DOUBLE;
      if (len == 5 && kw == word6("float")) return K_DOUBLE;
      if (len == 4 && kw == word6("void")) return K_VOID;
      if (len == 4 && kw == word6("auto")) return K_AUTO;
      if (len == 3 && kw == word6("for")) return K_FOR;
      if (len == 2 && kw == word6("if")) return K_IF;
      if (len == 4 && kw == word6("else")) return K_ELSE;
      if (len == 6 && kw == word6("return")) return K_RETURN;
      if (len == 4 && kw == word6("QReg")) return K_QREG;
      if (len == 3 && (kw == word6("Bit") || kw == word6("bit"))) return K_BIT;
      if (len == 6 && kw == word6("Oracle")) return K_ORACLE;
      return K_IDENT;
   endfunction

   function automatic logic [5:0] lone_kind(logic [7:0] c);
      case (c)
         "[": return K_LBRACK;  "]": return K_RBRACK;  "(": return K_LPAREN;
         ")": return K_RPAREN;  "{": return K_LBRACE;  "}": return K_RBRACE;
         ",": return K_COMMA;   ";": return K_SEMI;    ":": return K_COLON;
         ".": return K_DOT;     "=": return K_ASSIGN;  "<": return K_LT;
         ">": return K_GT;      "+": return K_PLUS;    "-": return K_MINUS;
         "*": return K_STAR;    "/": return K_SLASH;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] two_char_kind(logic [7:0] a, logic [7:0] b);
      if (a == "[" && b == "[") return K_LATTR;
      if (a == "]" && b == "]") return K_RATTR;
      if (a == "+" && b == "+") return K_INC;
      if (a == "-" && b == "-") return K_DEC;
      if (a == "-" && b == ">") return K_ARROW;
      if (a == ":" && b == ":") return K_SCOPE;
      if (a == "=" && b == "=") return K_EQ;
      if (a == "!" && b == "=") return K_NE;
      if (a == "<" && b == "=") return K_LE;
      if (a == ">" && b == "=") return K_GE;
      if (a == "&" && b == "&") return K_ANDAND;
      return K_NONE;
   endfunction

   function automatic bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit holds_for_pair(logic [7:0] c);
      return c == "[" || c == "]" || c == "+" || c == "-" || c == ":" || c == "=" ||
             c == "!" || c == "<" || c == ">" || c == "&" || c == "/";
   endfunction

   function automatic void push_token(logic [5:0] k, logic [15:0] ln, logic [15:0] col,
                                      logic [23:0] off, logic [15:0] len);
      rsp_type t;
      t = '{token_kind: k, start_line: ln, start_column: col, start_offset: off,
            token_length: len, last_of_run: 1'b0};
      step_tokens = {step_tokens, t};
   endfunction

   function automatic void clear_lexer();
      lx_mode = LM_IDLE; lx_held = 0; tk_line = 1; tk_col = 1; tk_off = 0; tk_len = 0;
      kw_buf = 0; cur_line = 1; cur_col = 1; cur_off = 0;
   endfunction

   function automatic void append_char(logic [7:0] c);
      if (tk_len < 6) kw_buf[8*tk_len +: 8] = c;
      tk_len = inc16(tk_len, 1);
   endfunction

   function automatic void open_token(logic [3:0] m, logic [7:0] c);
      lx_mode = m; tk_line = at_line; tk_col = at_col; tk_off = at_off;
      tk_len = 0; kw_buf = 0;
      append_char(c);
   endfunction

   function automatic void close_token();
      case (lx_mode)
         LM_IDENT: push_token(keyword_of(kw_buf, tk_len), tk_line, tk_col, tk_off, tk_len);
         LM_INT: push_token(K_INTEGER, tk_line, tk_col, tk_off, tk_len);
         LM_DOT: push_token(K_REAL, tk_line, tk_col, tk_off, inc16(tk_len, 1));
         LM_FRAC, LM_EXP, LM_EXPD: push_token(K_REAL, tk_line, tk_col, tk_off, tk_len);
         LM_HELD: push_token(lone_kind(lx_held), tk_line, tk_col, tk_off, 1);
         default: return;
      endcase
      lx_mode = LM_IDLE;
   endfunction

   // Returns 1 when the character is used up, 0 when it must be seen again.
   function automatic bit lex_char(logic [7:0] c);
      logic [5:0] k;
      case (lx_mode)
         LM_IDLE: begin
            if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return 1;
            if (c == "#" && at_col == 1) begin
               lx_mode = LM_LINE; col_frozen = 1; return 1;
            end
            if (letter(c) || c == "_") open_token(LM_IDENT, c);
            else if (digit(c)) open_token(LM_INT, c);
            else if (holds_for_pair(c)) begin
               open_token(LM_HELD, c); lx_held = c;
            end else push_token(lone_kind(c), at_line, at_col, at_off, 1);
            return 1;
         end
         LM_IDENT: begin
            if (letter(c) || digit(c) || c == "_") begin
               append_char(c); return 1;
            end
         end
         LM_INT: begin
            if (digit(c)) begin
               append_char(c); return 1;
            end
            if (c == ".") begin
               lx_mode = LM_DOT; return 1;
            end
            if (c == "e" || c == "E") begin
               append_char(c); lx_mode = LM_EXP; return 1;
            end
         end
         LM_DOT: begin
            if (c == ".") begin
               push_token(K_INTEGER, tk_line, tk_col, tk_off, tk_len);
               push_token(K_DOT, tk_line, inc16(tk_col, tk_len),
                          at_off > 0 ? at_off - 24'd1 : 24'd0, 1);
               lx_mode = LM_IDLE;
               return 0;
            end
            append_char(".");
            lx_mode = LM_FRAC;
            return 0;
         end
         LM_FRAC: begin
            if (digit(c)) begin
               append_char(c); return 1;
            end
            if (c == "e" || c == "E") begin
               append_char(c); lx_mode = LM_EXP; return 1;
            end
         end
         LM_EXP: begin
            if (c == "+" || c == "-" || digit(c)) begin
               append_char(c); lx_mode = LM_EXPD; return 1;
            end
         end
         LM_EXPD: begin
            if (digit(c)) begin
               append_char(c); return 1;
            end
         end
         LM_HELD: begin
            k = two_char_kind(lx_held, c);
            if (k != K_NONE) begin
               push_token(k, tk_line, tk_col, tk_off, 2);
               lx_mode = LM_IDLE; lx_held = 0; return 1;
            end
            if (lx_held == "/" && c == "/") begin
               lx_mode = LM_LINE; cur_col = tk_col; col_frozen = 1; lx_held = 0; return 1;
            end
            if (lx_held == "/" && c == "*") begin
               lx_mode = LM_BLOCK; lx_held = 0; return 1;
            end
            close_token(); lx_held = 0; return 0;
         end
         LM_LINE: begin
            if (c == 8'h0A) begin
               lx_mode = LM_IDLE; return 0;
            end
            col_frozen = 1; return 1;
         end
         LM_BLOCK: begin
            if (c == "*") lx_mode = LM_BSTAR;
            return 1;
         end
         LM_BSTAR: begin
            if (c == "/") lx_mode = LM_IDLE;
            else if (c != "*") lx_mode = LM_BLOCK;
            return 1;
         end
         default: begin
            lx_mode = LM_IDLE; return 0;
         end
      endcase
      close_token();
      return 0;
   endfunction

   task automatic predict_tokens(req_type r);
      step_tokens.delete();
      col_frozen = 0;
      at_line = cur_line; at_col = cur_col; at_off = cur_off;
      if (r.command == CMD_END) begin
         close_token();
         push_token(K_EOF, cur_line, cur_col, cur_off, 0);
         clear_lexer();
      end else begin
         for (int i = 0; i < 4; i++) if (lex_char(r.data_byte)) break;
         if (cur_off != 24'hFFFFFF) cur_off = cur_off + 1;
         if (r.data_byte == 8'h0A) begin
            cur_line = inc16(cur_line, 1); cur_col = 1;
         end else if (!col_frozen) cur_col = inc16(cur_col, 1);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
      foreach (step_tokens[i]) token_queue = {token_queue, step_tokens[i]};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_tokens(req_data);
            void'(pending_bytes.pop_front());
         end
         if (pending_bytes.size() > 0 &&
             (req_push && req_full || $urandom_range(99) >= send_idle_pct)) begin
            req_push <= 1'b1;
            req_data <= pending_bytes[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (token_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected token beat %p", rsp_data);
            end else begin
               want = token_queue.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("token mismatch: expected %p, got %p",
                                                 want, rsp_data);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic add_byte(logic [7:0] b);
      pending_bytes = {pending_bytes, req_type'{command: CMD_BYTE, data_byte: b}};
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_end();
      pending_bytes = {pending_bytes, req_type'{command: CMD_END, data_byte: 8'($urandom)}};
   endtask

   task automatic add_random_source(int n);
      string frags[] = '{"int ", "double", "float", "void", "auto", "for", "if", "else",
         "return", "QReg", "Bit", "bit", "Oracle", "x_1", "abcdefgh", "42", "3.14", "7..",
         "1e5", "2.5E-3", "6e+", "[[", "]]", "->", "::", "==", "!=", "<=", ">=", "&&",
         "++", "--", "/* c * x **/", "// note\n", "\n#inc x\n", "(", ")", "{", "}", ";",
         ",", " ", "\n", "\t", "*", "/", "!", "&", "@", "9."};
      int len;
      len = 0;
      while (len < n) begin
         if ($urandom_range(9) == 0) begin
            add_byte(8'($urandom)); len++;
         end else begin
            string f;
            f = frags[$urandom_range(frags.size() - 1)];
            add_text(f); len += f.len();
         end
      end
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || token_queue.size() > 0 || req_push)
         @(posedge clock);
   endtask

   initial begin
      clear_lexer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_text("#x\nint double float void auto for if else return QReg Bit bit Oracle");
      add_end();
      add_text("12..3.5 7.x 1e+9 [[ ]] -> :: == != <= >= && ++ -- ! & //c\n/* * **/");
      add_text("[](){},;:.=<>+-*/~");
      add_byte(8'hFF); add_byte(8'h00); add_byte(8'h80); add_byte(8'h7F);
      add_text("x#"); add_text("/* open");
      add_end();
      add_text("5."); add_end();
      add_text("<"); add_end();
      drain();

      add_random_source(90); add_end();
      drain();

      send_idle_pct = 86; recv_idle_pct = 19;
      add_random_source(85); add_end();
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      hold_cycles = 60;
      add_random_source(80); add_end();
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && token_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

endmodule
